[design/min_priority_queue_macros.svh]
// Assertion macros used by the assertion checker of the priority queue.
`ifndef MIN_PRIORITY_QUEUE_MACROS_SVH
`define MIN_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define MPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, clocked on aclk, off during reset.
`define MPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

[design/mpq_pkg.sv]
package mpq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    localparam logic ACT_INSERT  = 1'b0;
    localparam logic ACT_EXTRACT = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_SHIFT = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

endpackage

[design/min_priority_queue.sv]
// Insert, and extract from an empty queue: the result goes from the DONE state into the output
// registers once they are free. Extract from a filled queue: a scan of every held entry for the
// minimum, then compaction of the entries above it, at one read per cycle on the entry memory.
// One request is worked at a time; s_ready returns with the registered result, so the next is taken
// even while that result waits. Reset (aresetn low at a clock edge) empties the queue and
// drops any pending result; the entry memory is not cleared, entries are only read below the fill count.
module min_priority_queue (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_action,
    input  logic signed [mpq_pkg::DATA_W-1:0]    s_priority_req,
    input  logic signed [mpq_pkg::DATA_W-1:0]    s_payload,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic        [mpq_pkg::STAT_W-1:0]    m_status,
    output logic signed [mpq_pkg::DATA_W-1:0]    m_result_value,
    output logic        [mpq_pkg::OCC_W-1:0]     m_occupancy
);

    localparam int DW = mpq_pkg::DATA_W;
    localparam int CW = mpq_pkg::CNT_W;
    localparam int IW = mpq_pkg::IDX_W;

    logic [2*DW-1:0] mem [mpq_pkg::DEPTH];
    logic [2*DW-1:0] rd_data_reg;
    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    logic [IW-1:0]   mem_raddr;
    logic [2*DW-1:0] mem_wdata;

    mpq_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   iss_reg, iss_next;
    logic            rv_reg, rv_next;
    logic [CW-1:0]   ri_reg, ri_next;
    logic            have_best_reg, have_best_next;
    logic signed [DW-1:0] best_prio_reg, best_prio_next;
    logic signed [DW-1:0] best_val_reg, best_val_next;
    logic [CW-1:0]   best_idx_reg, best_idx_next;
    logic [mpq_pkg::STAT_W-1:0] res_status_reg, res_status_next;
    logic signed [DW-1:0] res_value_reg, res_value_next;
    logic            m_valid_reg, m_valid_next;
    logic [mpq_pkg::STAT_W-1:0] m_status_reg, m_status_next;
    logic signed [DW-1:0] m_value_reg, m_value_next;
    logic [mpq_pkg::OCC_W-1:0] m_occ_reg, m_occ_next;

    logic signed [DW-1:0] cand_prio;
    logic                 take_cand;

    assign s_ready        = (state_reg == mpq_pkg::ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_result_value = m_value_reg;
    assign m_occupancy    = m_occ_reg;

    assign cand_prio = rd_data_reg[2*DW-1:DW];
    assign take_cand = !have_best_reg || (cand_prio <= best_prio_reg);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        iss_next        = iss_reg;
        rv_next         = 1'b0;
        ri_next         = ri_reg;
        have_best_next  = have_best_reg;
        best_prio_next  = best_prio_reg;
        best_val_next   = best_val_reg;
        best_idx_next   = best_idx_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_value_next    = m_value_reg;
        m_occ_next      = m_occ_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[IW-1:0];
        mem_wdata       = {s_priority_req, s_payload};
        mem_raddr       = iss_reg[IW-1:0];

        case (state_reg)
            mpq_pkg::ST_IDLE: begin
                if (s_valid) begin
                    res_value_next = '0;
                    res_status_next = mpq_pkg::STAT_OK;
                    state_next = mpq_pkg::ST_DONE;
                    if (s_action == mpq_pkg::ACT_INSERT) begin
                        if (count_reg == CW'(mpq_pkg::DEPTH)) begin
                            res_status_next = mpq_pkg::STAT_FULL;
                        end else begin
                            mem_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end else if (count_reg == '0) begin
                        res_status_next = mpq_pkg::STAT_EMPTY;
                    end else begin
                        iss_next       = '0;
                        have_best_next = 1'b0;
                        state_next     = mpq_pkg::ST_SCAN;
                    end
                end
            end
            mpq_pkg::ST_SCAN: begin
                if (iss_reg < count_reg) begin
                    rv_next  = 1'b1;
                    ri_next  = iss_reg;
                    iss_next = iss_reg + 1'b1;
                end
                if (rv_reg) begin
                    if (take_cand) begin
                        best_prio_next = cand_prio;
                        best_val_next  = rd_data_reg[DW-1:0];
                        best_idx_next  = ri_reg;
                        have_best_next = 1'b1;
                    end
                    if (ri_reg == CW'(count_reg - 1'b1)) begin
                        iss_next   = CW'(best_idx_next + 1'b1);
                        state_next = mpq_pkg::ST_SHIFT;
                    end
                end
            end
            mpq_pkg::ST_SHIFT: begin
                if (iss_reg < count_reg) begin
                    rv_next  = 1'b1;
                    ri_next  = CW'(iss_reg - 1'b1);
                    iss_next = iss_reg + 1'b1;
                end
                if (rv_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = ri_reg[IW-1:0];
                    mem_wdata = rd_data_reg;
                end
                if (iss_reg >= count_reg && !rv_reg) begin
                    count_next      = count_reg - 1'b1;
                    res_status_next = mpq_pkg::STAT_OK;
                    res_value_next  = best_val_reg;
                    state_next      = mpq_pkg::ST_DONE;
                end
            end
            mpq_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_value_next  = res_value_reg;
                    m_occ_next    = mpq_pkg::OCC_W'(count_reg);
                    state_next    = mpq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mpq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mpq_pkg::ST_IDLE;
            count_reg   <= '0;
            rv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rv_reg      <= rv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        iss_reg        <= iss_next;
        ri_reg         <= ri_next;
        have_best_reg  <= have_best_next;
        best_prio_reg  <= best_prio_next;
        best_val_reg   <= best_val_next;
        best_idx_reg   <= best_idx_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        m_status_reg   <= m_status_next;
        m_value_reg    <= m_value_next;
        m_occ_reg      <= m_occ_next;
    end

endmodule

[design/mpq_checker.sv]
`include "min_priority_queue_macros.svh"

module mpq_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic                                 s_action,
    input logic signed [mpq_pkg::DATA_W-1:0]    s_priority_req,
    input logic signed [mpq_pkg::DATA_W-1:0]    s_payload,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic        [mpq_pkg::STAT_W-1:0]    m_status,
    input logic signed [mpq_pkg::DATA_W-1:0]    m_result_value,
    input logic        [mpq_pkg::OCC_W-1:0]     m_occupancy
);

    `MPQ_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_result_value) && $stable(m_occupancy))

    `MPQ_ASSERT_NOW(a_status_code, m_valid, m_status == mpq_pkg::STAT_OK || m_status == mpq_pkg::STAT_FULL || m_status == mpq_pkg::STAT_EMPTY)

    `MPQ_ASSERT_NOW(a_full_reject, m_valid && m_status == mpq_pkg::STAT_FULL, m_result_value == '0 && m_occupancy == mpq_pkg::OCC_W'(mpq_pkg::DEPTH))

    `MPQ_ASSERT_NOW(a_empty_fail, m_valid && m_status == mpq_pkg::STAT_EMPTY, m_result_value == '0 && m_occupancy == '0)

endmodule

bind min_priority_queue mpq_checker u_mpq_checker (.*);

[tb/min_priority_queue_checker.sv]
module min_priority_queue_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic                              s_action,
    input  logic signed [mpq_pkg::DATA_W-1:0] s_priority_req,
    input  logic signed [mpq_pkg::DATA_W-1:0] s_payload,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic        [mpq_pkg::STAT_W-1:0] m_status,
    input  logic signed [mpq_pkg::DATA_W-1:0] m_result_value,
    input  logic        [mpq_pkg::OCC_W-1:0]  m_occupancy,
    output int                                mismatches,
    output int                                awaiting,
    output int                                responses,
    output int                                full_rejects,
    output int                                empty_extracts
);
    timeunit 1ns;
    timeprecision 1ps;

    import mpq_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic        [STAT_W-1:0] status;
        logic signed [DATA_W-1:0] value;
        logic        [OCC_W-1:0]  occupancy;
    } response_t;

    logic signed [DATA_W-1:0] held_prio  [DEPTH];
    logic signed [DATA_W-1:0] held_value [DEPTH];
    int        held_count = 0;
    response_t awaited_responses[$];

    int mismatch_count = 0;
    int awaiting_count = 0;
    int response_count = 0;
    int full_count     = 0;
    int empty_count    = 0;

    assign mismatches     = mismatch_count;
    assign awaiting       = awaiting_count;
    assign responses      = response_count;
    assign full_rejects   = full_count;
    assign empty_extracts = empty_count;

    // Latest entry wins a tie on the smallest priority.
    function automatic response_t queue_response(input logic action,
                                                 input logic signed [DATA_W-1:0] prio,
                                                 input logic signed [DATA_W-1:0] value);
        response_t r;
        int        best;
        r.status = STAT_OK;
        r.value  = '0;
        if (action == ACT_INSERT) begin
            if (held_count >= DEPTH) begin
                r.status = STAT_FULL;
            end else begin
                held_prio[held_count]  = prio;
                held_value[held_count] = value;
                held_count++;
            end
        end else if (held_count == 0) begin
            r.status = STAT_EMPTY;
        end else begin
            best = 0;
            for (int i = 1; i < held_count; i++) begin
                if (held_prio[i] <= held_prio[best])
                    best = i;
            end
            r.value = held_value[best];
            for (int i = best; i + 1 < held_count; i++) begin
                held_prio[i]  = held_prio[i + 1];
                held_value[i] = held_value[i + 1];
            end
            held_count--;
        end
        r.occupancy = OCC_W'(held_count);
        return r;
    endfunction

    task automatic log_mismatch(input string why, input response_t want, input response_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s: expected status %0d value %0d occupancy %0d, got status %0d value %0d occupancy %0d",
                     $realtime, why, want.status, want.value, want.occupancy,
                     got.status, got.value, got.occupancy);
    endtask

    always @(posedge aclk) begin
        response_t want;
        response_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{m_status, m_result_value, m_occupancy};
                response_count++;
                if (got.status == STAT_FULL)
                    full_count++;
                if (got.status == STAT_EMPTY)
                    empty_count++;
                if (awaited_responses.size() == 0) begin
                    log_mismatch("response with no request outstanding", '0, got);
                end else begin
                    want = awaited_responses.pop_front();
                    if (got.status !== want.status || got.value !== want.value
                            || got.occupancy !== want.occupancy)
                        log_mismatch("response mismatch", want, got);
                end
            end
            if (s_valid && s_ready)
                awaited_responses.push_back(queue_response(s_action, s_priority_req, s_payload));
            awaiting_count = awaited_responses.size();
        end
    end

endmodule

[tb/min_priority_queue_tb.sv]
module min_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mpq_pkg::*;

    localparam int ITEM_TARGET  = 2000;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
    localparam int IDLE_PCT     = 33;

    localparam logic signed [DATA_W-1:0] P_MAX = 32'sh7fffffff;
    localparam logic signed [DATA_W-1:0] P_MIN = 32'sh80000000;

    localparam logic signed [DATA_W-1:0] FILL_PRIO [16] = '{
        32'sd0, -32'sd1, P_MAX, P_MIN, 32'sd5, P_MIN, 32'sd3, 32'sd0,
        -32'sd1, P_MAX, 32'sd7, P_MIN, 32'sd2, 32'sh80000001, 32'sd1, 32'sd0
    };
    localparam logic signed [DATA_W-1:0] FILL_VALUE [16] = '{
        P_MAX, P_MIN, 32'sd0, -32'sd1, 32'sh55555555, 32'shaaaaaaaa, 32'sd6, 32'sd7,
        32'sd8, 32'sd9, 32'sh0f0f0f0f, 32'shf0f0f0f0, 32'sd12, 32'sd13, 32'sd14, 32'sd15
    };

    logic                     aclk;
    logic                     aresetn        = 1'b0;
    logic                     s_valid        = 1'b0;
    logic                     s_ready;
    logic                     s_action       = ACT_INSERT;
    logic signed [DATA_W-1:0] s_priority_req = '0;
    logic signed [DATA_W-1:0] s_payload      = '0;
    logic                     m_valid;
    logic                     m_ready        = 1'b0;
    logic        [STAT_W-1:0] m_status;
    logic signed [DATA_W-1:0] m_result_value;
    logic        [OCC_W-1:0]  m_occupancy;

    int mismatches;
    int awaiting;
    int responses;
    int full_rejects;
    int empty_extracts;

    logic steady = 1'b0;
    int   inserts_sent  = 0;
    int   extracts_sent = 0;
    int   cycles;

    min_priority_queue u_top (.*);

    min_priority_queue_checker u_check (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    initial begin
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge aclk);
        $display("tb: failure");
        $finish;
    end

    task automatic send_request(input logic action,
                                input logic signed [DATA_W-1:0] prio,
                                input logic signed [DATA_W-1:0] value);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_action       <= action;
        s_priority_req <= prio;
        s_payload      <= value;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (action == ACT_INSERT)
            inserts_sent++;
        else
            extracts_sent++;
    endtask

    // Bias towards a narrow band so that ties on the minimum are common.
    function automatic logic signed [DATA_W-1:0] pick_priority();
        case ($urandom_range(0, 3))
            0, 1:    return $signed(32'($urandom_range(0, 8))) - 32'sd4;
            2: begin
                case ($urandom_range(0, 3))
                    0:       return P_MIN;
                    1:       return P_MAX;
                    2:       return -32'sd1;
                    default: return 32'sd0;
                endcase
            end
            default: return $signed($urandom());
        endcase
    endfunction

    initial begin
        int   fill_bias;
        logic action;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(ACT_EXTRACT, P_MAX, P_MIN);
        for (int i = 0; i < DEPTH; i++)
            send_request(ACT_INSERT, FILL_PRIO[i % 16], FILL_VALUE[i % 16]);
        send_request(ACT_INSERT, P_MIN, P_MAX);
        send_request(ACT_INSERT, P_MAX, P_MIN);
        repeat (6) send_request(ACT_EXTRACT, $signed($urandom()), $signed($urandom()));

        fill_bias = 50;
        for (int n = 0; n < ITEM_TARGET; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 3))
                    0:       fill_bias = 20;
                    1:       fill_bias = 80;
                    default: fill_bias = 50;
                endcase
            end
            steady <= (n >= 900 && n < 1200);
            action = ($urandom_range(0, 99) < fill_bias) ? ACT_INSERT : ACT_EXTRACT;
            send_request(action, pick_priority(), $signed($urandom()));
        end
        s_valid <= 1'b0;
        steady  <= 1'b0;

        @(posedge aclk);
        while (awaiting != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("tb: %0d inserts and %0d extracts sent, %0d responses checked",
                 inserts_sent, extracts_sent, responses);
        $display("tb: %0d inserts refused on a full queue, %0d extracts on an empty queue",
                 full_rejects, empty_extracts);
        if (mismatches == 0 && awaiting == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
